// ===== rtl/cdd_pkg.sv =====
// Shared types, widths and calendar tables for the calendar day difference block.
package cdd_pkg;

    localparam int YEAR_W  = 7;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 17;
    localparam int DOY_W   = 10;
    localparam int SPAN_W  = 16;
    localparam int CUM_W   = 9;

    // Year offset of 2100, the one century year in range that is not a leap year
    localparam logic [YEAR_W-1:0] CENTURY_OFF = 7'd100;

    // First month whose day of year includes the leap day
    localparam logic [MONTH_W-1:0] MARCH = 4'd3;

    localparam logic [8:0] DAYS_PER_YEAR = 9'd365;

    // Days before each month in a common year; month zero counts like January,
    // months above twelve count the whole year
    localparam logic [CUM_W-1:0] CUM_DAYS [16] = '{
        9'd0,   9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365, 9'd365, 9'd365
    };

    typedef struct packed {
        logic [YEAR_W-1:0]  start_year;
        logic [MONTH_W-1:0] start_month;
        logic [DAY_W-1:0]   start_day;
        logic [YEAR_W-1:0]  end_year;
        logic [MONTH_W-1:0] end_month;
        logic [DAY_W-1:0]   end_day;
    } cdd_in_t;

    typedef struct packed {
        logic signed [COUNT_W-1:0] day_count;
        logic                      order_error;
    } cdd_out_t;

    typedef struct packed {
        logic              order_error;
        logic [SPAN_W-1:0] span;
    } cdd_span_t;

endpackage

// ===== rtl/cdd_day_of_year.sv =====
// Day of year (January 1st is zero) from a year offset, month and day.
module cdd_day_of_year (
    input  logic [cdd_pkg::YEAR_W-1:0]         year,
    input  logic [cdd_pkg::MONTH_W-1:0]        month,
    input  logic [cdd_pkg::DAY_W-1:0]          day,
    output logic signed [cdd_pkg::DOY_W-1:0]   doy
);
    import cdd_pkg::*;

    logic             leap;
    logic             leap_add;
    logic [CUM_W-1:0] doy_plus_one;

    // Gregorian rule over 2000..2127: every fourth year except 2100
    assign leap = (year[1:0] == 2'b00) && (year != CENTURY_OFF);

    // Add the leap day once February has passed
    assign leap_add = leap && (month >= MARCH);

    assign doy_plus_one = CUM_DAYS[month] + CUM_W'(leap_add) + CUM_W'(day);
    assign doy          = $signed({1'b0, doy_plus_one}) - DOY_W'(1);

endmodule

// ===== rtl/cdd_year_span.sv =====
// Days covered by the whole years between two year offsets, with order check.
module cdd_year_span (
    input  logic [cdd_pkg::YEAR_W-1:0] start_year,
    input  logic [cdd_pkg::YEAR_W-1:0] end_year,
    output cdd_pkg::cdd_span_t         span_info
);
    import cdd_pkg::*;

    logic [YEAR_W-1:0] diff;
    logic [SPAN_W-1:0] year_days;
    logic [YEAR_W:0]   start_round;
    logic [YEAR_W:0]   end_round;
    logic [5:0]        start_leaps;
    logic [5:0]        end_leaps;

    assign diff      = end_year - start_year;
    assign year_days = SPAN_W'(diff) * SPAN_W'(DAYS_PER_YEAR);

    // Leap years among offsets below y: ceil(y/4), less one once 2100 is passed
    assign start_round = {1'b0, start_year} + (YEAR_W+1)'(3);
    assign end_round   = {1'b0, end_year} + (YEAR_W+1)'(3);
    assign start_leaps = start_round[YEAR_W:2] - 6'(start_year > CENTURY_OFF);
    assign end_leaps   = end_round[YEAR_W:2] - 6'(end_year > CENTURY_OFF);

    assign span_info.order_error = start_year > end_year;
    assign span_info.span        = year_days + SPAN_W'(end_leaps) - SPAN_W'(start_leaps);

endmodule

// ===== rtl/calendar_day_difference.sv =====
// Top level of the calendar day difference block: input and result registers.
//
// Usage:
//   Drive a date pair on request and raise start. busy is always low, so the
//   item is taken at every rising edge where start is high; a new pair may
//   be offered in every cycle.
//   The item passes the input register, then the result register; after
//   that, result holds day_count and order_error and done is high for
//   exactly one cycle.
//   Throughput: 1 item per cycle, set by the single pass of table lookup,
//   closed-form leap count and one add chain between the two registers.
//   order_error is set, with day_count at -1, when the start year is later
//   than the end year; same-year pairs may give a negative count.
//   Reset (rst_n low, asynchronous) drops any item in flight and clears done.
//   The receiver cannot stall: each result must be taken in its done cycle.
module calendar_day_difference (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  cdd_pkg::cdd_in_t  request,
    output cdd_pkg::cdd_out_t result,
    output logic              done
);
    import cdd_pkg::*;

    cdd_in_t                   req_reg;
    logic                      valid_reg;
    cdd_out_t                  result_reg;
    cdd_out_t                  result_next;
    logic                      done_reg;
    cdd_span_t                 span_info;
    logic signed [DOY_W-1:0]   doy_start;
    logic signed [DOY_W-1:0]   doy_end;
    logic signed [COUNT_W:0]   count_wide;

    assign busy = 1'b0;

    // Hold the accepted item
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            req_reg <= request;
        end
    end

    // Advance the valid marks through both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= start;
            done_reg  <= valid_reg;
        end
    end

    cdd_year_span u_span (
        .start_year (req_reg.start_year),
        .end_year   (req_reg.end_year),
        .span_info  (span_info)
    );

    cdd_day_of_year u_doy_start (
        .year  (req_reg.start_year),
        .month (req_reg.start_month),
        .day   (req_reg.start_day),
        .doy   (doy_start)
    );

    cdd_day_of_year u_doy_end (
        .year  (req_reg.end_year),
        .month (req_reg.end_month),
        .day   (req_reg.end_day),
        .doy   (doy_end)
    );

    // Combine year span and both days of year; force -1 on order error
    always_comb
    begin
        count_wide = $signed({2'b00, span_info.span}) + (COUNT_W+1)'(doy_end)
                   - (COUNT_W+1)'(doy_start);
        result_next.order_error = span_info.order_error;
        if (span_info.order_error)
        begin
            result_next.day_count = -COUNT_W'(1);
        end
        else
        begin
            result_next.day_count = count_wide[COUNT_W-1:0];
        end
    end

    // Hold the finished result
    always_ff @(posedge clk)
    begin
        if (valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

// ===== rtl/cdd_checker.sv =====
// Port-level checker for the calendar day difference block, with its bind.
module cdd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input cdd_pkg::cdd_in_t  request,
    input cdd_pkg::cdd_out_t result,
    input logic              done
);
    import cdd_pkg::*;

    // Each accepted item gives a strobe once its mark has passed valid_reg and done_reg
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("accepted item gave no result");

    // No strobe without an accepted item
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> ##1 !done)
        else $error("result strobe without accepted item");

    // Order error follows the years of the item that the strobe belongs to
    a_order_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(rst_n, 2)) |->
        (result.order_error == ($past(request.start_year, 2) > $past(request.end_year, 2))))
        else $error("order_error does not match item years");

    // An order error always reports a count of minus one
    a_error_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.order_error) |-> (result.day_count == -COUNT_W'(1)))
        else $error("order error with count other than -1");

endmodule

bind calendar_day_difference cdd_checker u_cdd_checker (.*);
